// ----- src/tpbd_pkg.sv -----
`default_nettype none

package tpbd_pkg;

    // Input event kinds
    localparam logic [1:0] KIND_WAVE  = 2'd0;
    localparam logic [1:0] KIND_PULSE = 2'd1;
    localparam logic [1:0] KIND_BIT   = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // Result kinds
    localparam logic [2:0] OUT_WAVE  = 3'd0;
    localparam logic [2:0] OUT_PULSE = 3'd1;
    localparam logic [2:0] OUT_BIT   = 3'd2;
    localparam logic [2:0] OUT_GAP   = 3'd3;
    localparam logic [2:0] OUT_OTHER = 3'd4;

    // Conversion modes (the unused code behaves as pass)
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;
    localparam logic [1:0] MODE_BITS  = 2'd2;

    // Command opcodes from front to back
    localparam logic [1:0] OP_PASS  = 2'd0; // flush queue as pulses, forward event
    localparam logic [1:0] OP_SPLIT = 2'd1; // flush queue as pulses, split event
    localparam logic [1:0] OP_OTHER = 2'd2; // flush queue as gaps, forward event
    localparam logic [1:0] OP_BITS  = 2'd3; // queue pulses and classify

    // Timing thresholds in 2 MHz cycles
    localparam logic [11:0] C_ONE_WIDE_MIN  = 12'd250;
    localparam logic [11:0] C_ONE_THIN_MAX  = 12'd550;
    localparam logic [11:0] C_ONE_WIDE_MAX  = 12'd600;
    localparam logic [11:0] C_ZERO_WIDE_MIN = 12'd490;
    localparam logic [11:0] C_ZERO_THIN_MIN = 12'd680;
    localparam logic [11:0] C_ZERO_WIDE_MAX = 12'd1100;
    localparam logic [11:0] C_WAVE_MIN      = 12'd1250;
    localparam logic [11:0] C_WAVE_MAX      = 12'd2100;

    // Control part of a command word
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic       level_high;
        logic       bit_value;
        logic       in_window;  // event length lies in the wave window
        logic       four;       // split into four pulses (one-bit)
        logic [7:0] phase;
        logic [3:0] other_code;
    } t_cmd_ctl;

    // One result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] length;
        logic        level_high;
        logic        bit_value;
        logic [7:0]  phase;
        logic [3:0]  other_code;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ----- src/tpbd_front.sv -----
`default_nettype none

module tpbd_front #(
    parameter int LENGTH_BITS = 24
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire  [1:0]               i_cfg_data,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire  [1:0]               i_event_kind,
    input  wire  [23:0]              i_event_length,
    input  wire                      i_level_high,
    input  wire                      i_bit_value,
    input  wire  [7:0]               i_phase_tag,
    input  wire  [3:0]               i_other_code,
    input  wire                      i_room,
    output logic                     o_push,
    output tpbd_pkg::t_cmd_ctl       o_ctl,
    output logic [LENGTH_BITS-1:0]   o_len
);
    import tpbd_pkg::*;

    localparam int L = LENGTH_BITS;

    logic [1:0]   r_mode;
    logic [L-1:0] len;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    assign len        = L'(i_event_length);
    assign o_in_ready = i_room;
    assign o_push     = i_in_valid && i_room;
    assign o_len      = len;

    // Classify the word into a command
    always_comb begin
        o_ctl            = '0;
        o_ctl.kind       = i_event_kind;
        o_ctl.level_high = i_level_high;
        o_ctl.bit_value  = i_bit_value;
        o_ctl.phase      = i_phase_tag;
        o_ctl.other_code = i_other_code;
        o_ctl.in_window  = (len >= L'(C_WAVE_MIN)) && (len < L'(C_WAVE_MAX));
        o_ctl.four       = (i_event_kind == KIND_BIT) && i_bit_value;
        if (r_mode == MODE_BITS) begin
            o_ctl.op = (i_event_kind == KIND_OTHER) ? OP_OTHER : OP_BITS;
        end else if ((r_mode == MODE_PULSE) &&
                     ((i_event_kind == KIND_WAVE) || (i_event_kind == KIND_BIT))) begin
            o_ctl.op = OP_SPLIT;
        end else begin
            o_ctl.op = OP_PASS;
        end
    end

endmodule

`default_nettype wire

// ----- src/tpbd_cmd_fifo.sv -----
`default_nettype none

module tpbd_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_wdata,
    output logic             o_room,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_room  = (r_cnt < CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd];
    assign push_ok = i_push && o_room;
    assign pop_ok  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/tpbd_back.sv -----
`default_nettype none

module tpbd_back #(
    parameter int PENDING_DEPTH = 8,
    parameter int LENGTH_BITS   = 24
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cmd_valid,
    input  tpbd_pkg::t_cmd_ctl       i_cmd_ctl,
    input  wire  [LENGTH_BITS-1:0]   i_cmd_len,
    output logic                     o_cmd_pop,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output tpbd_pkg::t_result        o_out
);
    import tpbd_pkg::*;

    localparam int L   = LENGTH_BITS;
    localparam int D   = PENDING_DEPTH;
    localparam int CW  = $clog2(D + 1);
    localparam int IW  = $clog2(D);
    localparam int SW2 = L + 1;
    localparam int SW4 = L + 2;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_FLUSH    = 3'd2;
    localparam logic [2:0] S_EVENT    = 3'd3;
    localparam logic [2:0] S_SPLIT    = 3'd4;
    localparam logic [2:0] S_PUSH     = 3'd5;
    localparam logic [2:0] S_CLASSIFY = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0]    r_state, n_state;
    t_cmd_ctl      r_ctl;
    logic [L-1:0]  r_len;
    logic [1:0]    r_idx, n_idx;
    logic [CW-1:0] r_count;

    // Pulse queue, contents valid below r_count only
    logic [L-1:0]  r_pend_len   [D];
    logic          r_pend_high  [D];
    logic [7:0]    r_pend_phase [D];

    t_result       r_hold, r_out, gen;
    logic          r_hold_v, r_out_v;

    logic          out_free, gen_ok, gen_req, gen_fire, fin_move;
    logic          do_push;
    logic [L-1:0]  push_len;
    logic          push_high;
    logic [2:0]    drop_n;

    logic [L:0]    len_p1, len_p2;
    logic [L-1:0]  split_len;
    logic [1:0]    last_idx;
    logic [SW2-1:0] sum2;
    logic [SW4-1:0] sum4;
    logic          zero_ok, one_ok, thin_any, bad_any;
    t_result       fwd;

    assign out_free  = !r_out_v || i_out_ready;
    assign gen_ok    = !r_hold_v || out_free;
    assign gen_fire  = gen_req && gen_ok;
    assign last_idx  = r_ctl.four ? 2'd3 : 2'd1;

    // Split lengths with rounding so the parts add up to the whole
    assign len_p1 = {1'b0, r_len} + SW2'(1);
    assign len_p2 = {1'b0, r_len} + SW2'(2);
    always_comb begin
        if (r_ctl.four) begin
            unique case (r_idx)
                2'd0, 2'd2: split_len = L'(len_p2 >> 2);
                2'd1:       split_len = (r_len >> 2) + L'(r_len[0]);
                2'd3:       split_len = r_len >> 2;
            endcase
        end else begin
            split_len = r_idx[0] ? (r_len >> 1) : L'(len_p1 >> 1);
        end
    end

    // Zero and one tests over the queue head
    function automatic logic wide_zero(input logic [L-1:0] l);
        wide_zero = (l >= L'(C_ZERO_WIDE_MIN)) && (l < L'(C_ZERO_WIDE_MAX));
    endfunction

    assign sum2 = SW2'(r_pend_len[0]) + SW2'(r_pend_len[1]);
    assign sum4 = SW4'(sum2) + SW4'(r_pend_len[2]) + SW4'(r_pend_len[3]);

    assign zero_ok = (sum2 >= SW2'(C_WAVE_MIN)) && (sum2 < SW2'(C_WAVE_MAX)) &&
                     (((r_pend_len[0] >= L'(C_ZERO_THIN_MIN)) && wide_zero(r_pend_len[1])) ||
                      ((r_pend_len[1] >= L'(C_ZERO_THIN_MIN)) && wide_zero(r_pend_len[0])));

    always_comb begin
        thin_any = 1'b0;
        bad_any  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_pend_len[i] < L'(C_ONE_THIN_MAX)) begin
                thin_any = 1'b1;
            end
            if ((r_pend_len[i] < L'(C_ONE_WIDE_MIN)) ||
                (r_pend_len[i] >= L'(C_ONE_WIDE_MAX))) begin
                bad_any = 1'b1;
            end
        end
    end

    assign one_ok = (sum4 >= SW4'(C_WAVE_MIN)) && (sum4 < SW4'(C_WAVE_MAX)) &&
                    thin_any && !bad_any;

    // Forwarded event as a result
    always_comb begin
        fwd            = '0;
        fwd.kind       = (r_ctl.kind == KIND_OTHER) ? OUT_OTHER : {1'b0, r_ctl.kind};
        fwd.length     = 24'(r_len);
        fwd.level_high = (r_ctl.kind == KIND_PULSE) && r_ctl.level_high;
        fwd.bit_value  = (r_ctl.kind == KIND_BIT) && r_ctl.bit_value;
        fwd.phase      = r_ctl.phase;
        fwd.other_code = (r_ctl.kind == KIND_OTHER) ? r_ctl.other_code : 4'd0;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_cmd_pop = 1'b0;
        gen_req   = 1'b0;
        gen       = '0;
        fin_move  = 1'b0;
        do_push   = 1'b0;
        push_len  = split_len;
        push_high = r_idx[0];
        drop_n    = 3'd0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_idx     = 2'd0;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_ctl.op != OP_BITS) begin
                    n_state = S_FLUSH;
                end else if ((r_count == '0) && (r_ctl.kind == KIND_BIT)) begin
                    gen_req = 1'b1;
                    gen     = fwd;
                    if (gen_ok) begin
                        n_state = S_FINISH;
                    end
                end else if ((r_count == '0) && (r_ctl.kind == KIND_WAVE) &&
                             r_ctl.in_window) begin
                    gen_req    = 1'b1;
                    gen.kind   = OUT_BIT;
                    gen.length = 24'(r_len);
                    gen.phase  = r_ctl.phase;
                    if (gen_ok) begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_FLUSH: begin
                if (r_count == '0) begin
                    n_state = (r_ctl.op == OP_SPLIT) ? S_SPLIT : S_EVENT;
                end else begin
                    gen_req    = 1'b1;
                    gen.kind   = (r_ctl.op == OP_OTHER) ? OUT_GAP : OUT_PULSE;
                    gen.length = 24'(r_pend_len[0]);
                    gen.level_high = (r_ctl.op != OP_OTHER) && r_pend_high[0];
                    gen.phase  = r_pend_phase[0];
                    if (gen_ok) begin
                        drop_n = 3'd1;
                    end
                end
            end
            S_EVENT: begin
                gen_req = 1'b1;
                gen     = fwd;
                if (gen_ok) begin
                    n_state = S_FINISH;
                end
            end
            S_SPLIT: begin
                gen_req        = 1'b1;
                gen.kind       = OUT_PULSE;
                gen.length     = 24'(split_len);
                gen.level_high = r_idx[0];
                gen.phase      = r_ctl.phase;
                if (gen_ok) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == last_idx) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_PUSH: begin
                do_push = 1'b1;
                if (r_ctl.kind == KIND_PULSE) begin
                    push_len  = r_len;
                    push_high = r_ctl.level_high;
                    n_state   = S_CLASSIFY;
                end else begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == last_idx) begin
                        n_state = S_CLASSIFY;
                    end
                end
            end
            S_CLASSIFY: begin
                if (r_count < CW'(2)) begin
                    n_state = S_FINISH;
                end else if (zero_ok) begin
                    gen_req    = 1'b1;
                    gen.kind   = OUT_BIT;
                    gen.length = 24'(sum2);
                    gen.phase  = r_pend_phase[0];
                    if (gen_ok) begin
                        drop_n = 3'd2;
                    end
                end else if (r_count < CW'(4)) begin
                    n_state = S_FINISH;
                end else if (one_ok) begin
                    gen_req       = 1'b1;
                    gen.kind      = OUT_BIT;
                    gen.length    = 24'(sum4);
                    gen.bit_value = 1'b1;
                    gen.phase     = r_pend_phase[0];
                    if (gen_ok) begin
                        drop_n = 3'd4;
                    end
                end else begin
                    gen_req    = 1'b1;
                    gen.kind   = OUT_GAP;
                    gen.length = 24'(r_pend_len[0]);
                    gen.phase  = r_pend_phase[0];
                    if (gen_ok) begin
                        drop_n = 3'd1;
                    end
                end
            end
            S_FINISH: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    fin_move = 1'b1;
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Command latch
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_ctl <= i_cmd_ctl;
            r_len <= i_cmd_len;
        end
    end

    // Pulse queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_push && (r_count < CW'(D))) begin
            r_count <= r_count + CW'(1);
        end else if (drop_n != 3'd0) begin
            r_count <= r_count - CW'(drop_n);
        end
    end

    // Pulse queue contents: append at the tail, shift out at the head
    always_ff @(posedge i_clk) begin
        if (do_push && (r_count < CW'(D))) begin
            r_pend_len[r_count[IW-1:0]]   <= push_len;
            r_pend_high[r_count[IW-1:0]]  <= push_high;
            r_pend_phase[r_count[IW-1:0]] <= r_ctl.phase;
        end else begin
            for (int i = 0; i < D; i++) begin
                if ((drop_n == 3'd1) && (i + 1 < D)) begin
                    r_pend_len[i]   <= r_pend_len[i + 1];
                    r_pend_high[i]  <= r_pend_high[i + 1];
                    r_pend_phase[i] <= r_pend_phase[i + 1];
                end else if ((drop_n == 3'd2) && (i + 2 < D)) begin
                    r_pend_len[i]   <= r_pend_len[i + 2];
                    r_pend_high[i]  <= r_pend_high[i + 2];
                    r_pend_phase[i] <= r_pend_phase[i + 2];
                end else if ((drop_n == 3'd4) && (i + 4 < D)) begin
                    r_pend_len[i]   <= r_pend_len[i + 4];
                    r_pend_high[i]  <= r_pend_high[i + 4];
                    r_pend_phase[i] <= r_pend_phase[i + 4];
                end
            end
        end
    end

    // Hold stage: one result kept back until it is known whether it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
        end else if (gen_fire) begin
            r_hold_v <= 1'b1;
        end else if (fin_move) begin
            r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_fire) begin
            r_hold <= gen;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((gen_fire && r_hold_v) || fin_move) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_fire && r_hold_v) begin
            r_out      <= r_hold;
            r_out.last <= 1'b0;
        end else if (fin_move) begin
            r_out      <= r_hold;
            r_out.last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(D))
        else $error("pulse queue count above depth");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held result left behind at end of command");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && r_hold_v && out_free) |=> (r_out_v && r_out.last))
        else $error("final result not marked last");

    a_gen_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen_fire && r_hold_v) |-> out_free)
        else $error("result overwritten in output register");
`endif

endmodule

`default_nettype wire

// ----- src/tape_pulse_to_bit_decoder_unit.sv -----
`default_nettype none

// Channel   Handshake                      Payload
// input     i_in_valid / o_in_ready        i_event_kind .. i_other_code
// output    o_out_valid / i_out_ready      o_out_kind .. o_out_other_code, o_last
// config    i_cfg_we (no wait)             i_cfg_data
//
// A word passes the sequencer through pop, dispatch and finish, with a step per result,
// pulse appended and closing classify step, and one more to end a queue flush (pass,
// pulse, other); a word decoded whole in bit mode has its result in dispatch.
// Reset (synchronous, active low) clears mode, queue count, sequencer and valid
// flags; the pulse queue contents are not cleared.
// A two-word command queue lets the input run ahead; output stalls add cycles.

module tape_pulse_to_bit_decoder_unit #(
    parameter int PENDING_DEPTH = 8,
    parameter int LENGTH_BITS   = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_event_kind,
    input  wire  [23:0] i_event_length,
    input  wire         i_level_high,
    input  wire         i_bit_value,
    input  wire  [7:0]  i_phase_tag,
    input  wire  [3:0]  i_other_code,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_out_kind,
    output logic [23:0] o_out_length,
    output logic        o_out_level_high,
    output logic        o_out_bit_value,
    output logic [7:0]  o_out_phase,
    output logic [3:0]  o_out_other_code,
    output logic        o_last
);
    import tpbd_pkg::*;

    localparam int CMD_W = $bits(t_cmd_ctl) + LENGTH_BITS;

    logic                    room, push, cmd_valid, cmd_pop;
    t_cmd_ctl                push_ctl, cmd_ctl;
    logic [LENGTH_BITS-1:0]  push_len, cmd_len;
    logic [CMD_W-1:0]        cmd_word;
    t_result                 result;

    // Front: mode register and command classification
    tpbd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_event_kind   (i_event_kind),
        .i_event_length (i_event_length),
        .i_level_high   (i_level_high),
        .i_bit_value    (i_bit_value),
        .i_phase_tag    (i_phase_tag),
        .i_other_code   (i_other_code),
        .i_room         (room),
        .o_push         (push),
        .o_ctl          (push_ctl),
        .o_len          (push_len)
    );

    // Command queue between front and back
    tpbd_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({push_ctl, push_len}),
        .o_room  (room),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_rdata (cmd_word)
    );

    assign {cmd_ctl, cmd_len} = cmd_word;

    // Back: pulse queue, classifier and result sequencing
    tpbd_back #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_ctl   (cmd_ctl),
        .i_cmd_len   (cmd_len),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (result)
    );

    assign o_out_kind       = result.kind;
    assign o_out_length     = result.length;
    assign o_out_level_high = result.level_high;
    assign o_out_bit_value  = result.bit_value;
    assign o_out_phase      = result.phase;
    assign o_out_other_code = result.other_code;
    assign o_last           = result.last;

endmodule

`default_nettype wire

// ----- tb/tape_pulse_to_bit_decoder_unit_tb.sv -----
module tape_pulse_to_bit_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpbd_pkg::*;

    // Spare mode code, decodes as pass
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Pulse timing windows in 2 MHz cycles
    localparam int unsigned ONE_MIN      = 250;
    localparam int unsigned ONE_THIN_LIM = 550;
    localparam int unsigned ONE_MAX      = 600;
    localparam int unsigned ZERO_WIDE_LO = 490;
    localparam int unsigned ZERO_THIN_LO = 680;
    localparam int unsigned ZERO_WIDE_HI = 1100;
    localparam int unsigned WAVE_LO      = 1250;
    localparam int unsigned WAVE_HI      = 2100;

    localparam int unsigned LEN_MAX      = 32'h00FF_FFFF;
    localparam int          PULSE_SLOTS  = 8;
    localparam int          SETTLE_CYCLES = 64;
    localparam int unsigned RUN_LIMIT    = 600000;
    localparam int          PHASE_WORDS  = 27;

    typedef struct {
        logic [1:0]  kind;
        logic [23:0] len;
        logic        lvl;
        logic        bitv;
        logic [7:0]  phase;
        logic [3:0]  code;
    } t_tape_event;

    typedef struct packed {
        logic [23:0] len;
        logic        lvl;
        logic [7:0]  phase;
    } t_held_pulse;

    // Tracks decoder state and the results still owed by the block
    class tape_scoreboard;
        logic [1:0]  mode;
        t_held_pulse held[$];
        t_result     batch[$];
        t_result     expected[$];
        int          n_words;
        int          n_results;
        int          n_errors;

        function new();
            mode      = MODE_PASS;
            n_words   = 0;
            n_results = 0;
            n_errors  = 0;
        endfunction

        function int outstanding();
            return expected.size();
        endfunction

        function bit in_wave(int unsigned l);
            return l >= WAVE_LO && l < WAVE_HI;
        endfunction

        function void add_result(logic [2:0] k, int unsigned l, logic lv, logic bv,
                                 logic [7:0] ph, logic [3:0] oc);
            t_result r;
            r.kind       = k;
            r.length     = (l > LEN_MAX) ? 24'hFF_FFFF : l[23:0];
            r.level_high = lv;
            r.bit_value  = bv;
            r.phase      = ph;
            r.other_code = oc;
            r.last       = 1'b0;
            batch.push_back(r);
        endfunction

        function void hold_pulse(int unsigned l, logic lv, logic [7:0] ph);
            t_held_pulse p;
            p.len   = l[23:0];
            p.lvl   = lv;
            p.phase = ph;
            if (held.size() < PULSE_SLOTS) held.push_back(p);
        endfunction

        // One-bit -> low/high/low/high, wave or zero-bit -> low/high, lengths sum exactly
        function void cut_event(t_tape_event ev, bit to_queue);
            int unsigned l;
            int unsigned p[4];
            int          cnt;
            l = ev.len;
            if (ev.kind == KIND_BIT && ev.bitv) begin
                p[0] = (l + 2) >> 2;
                p[1] = (l >> 2) + (l & 1);
                p[2] = (l + 2) >> 2;
                p[3] = l >> 2;
                cnt  = 4;
            end else begin
                p[0] = (l + 1) >> 1;
                p[1] = l >> 1;
                cnt  = 2;
            end
            for (int i = 0; i < cnt; i++) begin
                if (to_queue) hold_pulse(p[i], i[0], ev.phase);
                else add_result(OUT_PULSE, p[i], i[0], 1'b0, ev.phase, 4'd0);
            end
        endfunction

        // Turn held pulses into zero-bits, one-bits or gaps
        function void decode_held();
            int unsigned a, b, pair, quad, l;
            bit          thin, bad;
            while (held.size() >= 2) begin
                a    = held[0].len;
                b    = held[1].len;
                pair = a + b;
                if (in_wave(pair) &&
                    ((a >= ZERO_THIN_LO && b >= ZERO_WIDE_LO && b < ZERO_WIDE_HI) ||
                     (b >= ZERO_THIN_LO && a >= ZERO_WIDE_LO && a < ZERO_WIDE_HI))) begin
                    add_result(OUT_BIT, pair, 1'b0, 1'b0, held[0].phase, 4'd0);
                    void'(held.pop_front());
                    void'(held.pop_front());
                    continue;
                end
                if (held.size() < 4) break;
                quad = pair + held[2].len + held[3].len;
                thin = 1'b0;
                bad  = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    l = held[i].len;
                    if (l < ONE_THIN_LIM) thin = 1'b1;
                    if (l < ONE_MIN || l >= ONE_MAX) bad = 1'b1;
                end
                if (in_wave(quad) && thin && !bad) begin
                    add_result(OUT_BIT, quad, 1'b0, 1'b1, held[0].phase, 4'd0);
                    repeat (4) void'(held.pop_front());
                end else begin
                    add_result(OUT_GAP, a, 1'b0, 1'b0, held[0].phase, 4'd0);
                    void'(held.pop_front());
                end
            end
        endfunction

        // Accepted input word: work out every result it causes
        function void note_word(t_tape_event ev);
            logic [2:0] fwd_kind;
            batch.delete();
            n_words++;
            if (mode != MODE_BITS) begin
                foreach (held[i])
                    add_result(OUT_PULSE, held[i].len, held[i].lvl, 1'b0, held[i].phase, 4'd0);
                held.delete();
                if (mode == MODE_PULSE && (ev.kind == KIND_WAVE || ev.kind == KIND_BIT)) begin
                    cut_event(ev, 1'b0);
                end else begin
                    case (ev.kind)
                        KIND_WAVE:  fwd_kind = OUT_WAVE;
                        KIND_PULSE: fwd_kind = OUT_PULSE;
                        KIND_BIT:   fwd_kind = OUT_BIT;
                        default:    fwd_kind = OUT_OTHER;
                    endcase
                    add_result(fwd_kind, ev.len,
                               (ev.kind == KIND_PULSE) ? ev.lvl : 1'b0,
                               (ev.kind == KIND_BIT) ? ev.bitv : 1'b0,
                               ev.phase,
                               (ev.kind == KIND_OTHER) ? ev.code : 4'd0);
                end
            end else if (ev.kind == KIND_OTHER) begin
                // held pulses leave as gaps ahead of the forwarded event
                foreach (held[i])
                    add_result(OUT_GAP, held[i].len, 1'b0, 1'b0, held[i].phase, 4'd0);
                held.delete();
                add_result(OUT_OTHER, ev.len, 1'b0, 1'b0, ev.phase, ev.code);
            end else if (held.size() == 0 && ev.kind == KIND_BIT) begin
                add_result(OUT_BIT, ev.len, 1'b0, ev.bitv, ev.phase, 4'd0);
            end else if (held.size() == 0 && ev.kind == KIND_WAVE && in_wave(ev.len)) begin
                add_result(OUT_BIT, ev.len, 1'b0, 1'b0, ev.phase, 4'd0);
            end else begin
                if (ev.kind == KIND_PULSE) hold_pulse(ev.len, ev.lvl, ev.phase);
                else cut_event(ev, 1'b1);
                decode_held();
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) expected.push_back(batch[i]);
        endfunction

        // Accepted output word against the oldest expectation
        function void check_result(t_result got);
            t_result want;
            if (expected.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: kind %0d len %0d phase %0d last %0d",
                             got.kind, got.length, got.phase, got.last);
                return;
            end
            want = expected.pop_front();
            n_results++;
            if (got.kind !== want.kind || got.length !== want.length ||
                got.level_high !== want.level_high || got.bit_value !== want.bit_value ||
                got.phase !== want.phase || got.other_code !== want.other_code ||
                got.last !== want.last) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("mismatch at result %0d:", n_results);
                    $display("  exp kind %0d len %0d lvl %0d bit %0d ph %0d code %0d last %0d",
                             want.kind, want.length, want.level_high, want.bit_value,
                             want.phase, want.other_code, want.last);
                    $display("  got kind %0d len %0d lvl %0d bit %0d ph %0d code %0d last %0d",
                             got.kind, got.length, got.level_high, got.bit_value,
                             got.phase, got.other_code, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_data       = 2'd0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_event_kind     = 2'd0;
    logic [23:0] i_event_length   = 24'd0;
    logic        i_level_high     = 1'b0;
    logic        i_bit_value      = 1'b0;
    logic [7:0]  i_phase_tag      = 8'd0;
    logic [3:0]  i_other_code     = 4'd0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic [2:0]  o_out_kind;
    logic [23:0] o_out_length;
    logic        o_out_level_high;
    logic        o_out_bit_value;
    logic [7:0]  o_out_phase;
    logic [3:0]  o_out_other_code;
    logic        o_last;

    tape_scoreboard sb;
    t_result        seen;
    bit             calm      = 1'b0;
    int             out_hold  = 0;
    int             n_cfg     = 0;
    int unsigned    cycles    = 0;

    tape_pulse_to_bit_decoder_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_event_kind     (i_event_kind),
        .i_event_length   (i_event_length),
        .i_level_high     (i_level_high),
        .i_bit_value      (i_bit_value),
        .i_phase_tag      (i_phase_tag),
        .i_other_code     (i_other_code),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_kind       (o_out_kind),
        .o_out_length     (o_out_length),
        .o_out_level_high (o_out_level_high),
        .o_out_bit_value  (o_out_bit_value),
        .o_out_phase      (o_out_phase),
        .o_out_other_code (o_out_other_code),
        .o_last           (o_last)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none in calm phases
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side stalls
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_ready = 1'b0;
            out_hold--;
        end else begin
            i_out_ready = 1'b1;
            out_hold = pick_gap();
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.kind       = o_out_kind;
            seen.length     = o_out_length;
            seen.level_high = o_out_level_high;
            seen.bit_value  = o_out_bit_value;
            seen.phase      = o_out_phase;
            seen.other_code = o_out_other_code;
            seen.last       = o_last;
            sb.check_result(seen);
        end
    end

    function automatic t_tape_event mk(logic [1:0] k, logic [23:0] l, logic lv, logic bv,
                                       logic [7:0] ph, logic [3:0] oc);
        t_tape_event ev;
        ev.kind  = k;
        ev.len   = l;
        ev.lvl   = lv;
        ev.bitv  = bv;
        ev.phase = ph;
        ev.code  = oc;
        return ev;
    endfunction

    function automatic logic [23:0] rand_length();
        case ($urandom_range(0, 5))
            0:       return 24'($urandom);
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom_range(0, 15));
            default: return 24'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic t_tape_event random_event();
        return mk(2'($urandom_range(0, 3)), rand_length(), 1'($urandom), 1'($urandom),
                  8'($urandom), 4'($urandom));
    endfunction

    // Drive one input word and hold it until taken
    task automatic send_word(input t_tape_event ev);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_event_kind   = ev.kind;
        i_event_length = ev.len;
        i_level_high   = ev.lvl;
        i_bit_value    = ev.bitv;
        i_phase_tag    = ev.phase;
        i_other_code   = ev.code;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(ev);
    endtask

    // Drain owed results, then give in-flight no-result words time to finish
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        settle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.mode    = m;
        n_cfg++;
    endtask

    // Bit-mode traffic: mostly well-formed tape symbols, some noise
    task automatic send_bits_traffic(output int sent);
        int          pick;
        int          n;
        logic        one;
        logic [23:0] l;
        pick = $urandom_range(0, 99);
        one  = 1'($urandom);
        sent = 1;
        if (pick < 50) begin
            n = one ? 4 : 2;
            for (int i = 0; i < n; i++) begin
                l = one ? 24'($urandom_range(320, 510)) : 24'($urandom_range(720, 980));
                if ($urandom_range(0, 9) == 0) l = 24'($urandom_range(100, 1400));
                send_word(mk(KIND_PULSE, l, i[0], 1'($urandom), 8'($urandom), 4'($urandom)));
            end
            sent = n;
        end else if (pick < 65) begin
            l = ($urandom_range(0, 4) == 0) ? rand_length() : 24'($urandom_range(1240, 2110));
            send_word(mk(KIND_WAVE, l, 1'($urandom), 1'($urandom), 8'($urandom),
                         4'($urandom)));
        end else if (pick < 75) begin
            l = ($urandom_range(0, 4) == 0) ? rand_length() : 24'($urandom_range(1200, 2150));
            send_word(mk(KIND_BIT, l, 1'($urandom), one, 8'($urandom), 4'($urandom)));
        end else if (pick < 90) begin
            send_word(mk(KIND_PULSE, rand_length(), 1'($urandom), 1'($urandom),
                         8'($urandom), 4'($urandom)));
        end else if (pick < 95) begin
            send_word(mk(KIND_OTHER, rand_length(), 1'($urandom), 1'($urandom),
                         8'($urandom), 4'($urandom)));
        end else begin
            send_word(random_event());
        end
    endtask

    initial begin
        int         sent;
        int         k;
        logic [1:0] plan [8];

        sb = new();

        // Reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pass mode straight from reset: field extremes
        send_word(mk(KIND_WAVE,  24'd0,       1'b0, 1'b0, 8'd0,   4'd0));
        send_word(mk(KIND_PULSE, 24'hFF_FFFF, 1'b1, 1'b1, 8'hFF,  4'hF));
        send_word(mk(KIND_BIT,   24'd1667,    1'b0, 1'b1, 8'd17,  4'd3));
        send_word(mk(KIND_OTHER, 24'd12345,   1'b1, 1'b0, 8'd200, 4'hF));

        // Pulse mode: rounding of odd and tiny lengths
        set_mode(MODE_PULSE);
        send_word(mk(KIND_WAVE,  24'hFF_FFFF, 1'b0, 1'b0, 8'd1,  4'd0));
        send_word(mk(KIND_BIT,   24'd1,       1'b0, 1'b1, 8'd2,  4'd0));
        send_word(mk(KIND_BIT,   24'd6,       1'b0, 1'b1, 8'd3,  4'd0));
        send_word(mk(KIND_BIT,   24'd7,       1'b1, 1'b0, 8'd4,  4'd0));
        send_word(mk(KIND_PULSE, 24'd500,     1'b0, 1'b0, 8'd5,  4'd0));
        send_word(mk(KIND_OTHER, 24'd9,       1'b0, 1'b0, 8'd6,  4'd5));

        // Bit mode
        set_mode(MODE_BITS);
        // whole wave in the window decodes directly
        send_word(mk(KIND_WAVE,  24'd1250,    1'b0, 1'b0, 8'd10, 4'd0));
        // wave at the window edge is split and held
        send_word(mk(KIND_WAVE,  24'd2100,    1'b0, 1'b0, 8'd11, 4'd0));
        // one-bit behind held pulses: split and queued, two gaps then a one
        send_word(mk(KIND_BIT,   24'd1667,    1'b0, 1'b1, 8'd12, 4'd0));
        // bit with empty queue is forwarded
        send_word(mk(KIND_BIT,   24'd900,     1'b0, 1'b0, 8'd13, 4'd0));
        // thin + wide pair gives a zero
        send_word(mk(KIND_PULSE, 24'd700,     1'b0, 1'b0, 8'd14, 4'd0));
        send_word(mk(KIND_PULSE, 24'd600,     1'b1, 1'b0, 8'd15, 4'd0));
        // four pulses at the one-bit limits give a one
        send_word(mk(KIND_PULSE, 24'd300,     1'b0, 1'b0, 8'd16, 4'd0));
        send_word(mk(KIND_PULSE, 24'd549,     1'b1, 1'b0, 8'd17, 4'd0));
        send_word(mk(KIND_PULSE, 24'd599,     1'b0, 1'b0, 8'd18, 4'd0));
        send_word(mk(KIND_PULSE, 24'd250,     1'b1, 1'b0, 8'd19, 4'd0));
        // other event flushes a held pulse as a gap
        send_word(mk(KIND_PULSE, 24'd800,     1'b0, 1'b0, 8'd20, 4'd0));
        send_word(mk(KIND_OTHER, 24'd33,      1'b0, 1'b0, 8'd21, 4'hA));
        // leave two pulses held across the mode change
        send_word(mk(KIND_PULSE, 24'd20,      1'b0, 1'b0, 8'd22, 4'd0));
        send_word(mk(KIND_PULSE, 24'd30,      1'b1, 1'b0, 8'd23, 4'd0));

        // Spare mode acts as pass and flushes the held pulses
        set_mode(MODE_SPARE);
        send_word(mk(KIND_WAVE,  24'd5,       1'b0, 1'b0, 8'd24, 4'd0));

        // Random phases, bit mode weighted
        plan = '{MODE_BITS, MODE_PULSE, MODE_BITS, MODE_PASS,
                 MODE_BITS, MODE_SPARE, MODE_BITS, MODE_PULSE};
        foreach (plan[p]) begin
            set_mode(plan[p]);
            calm = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if (plan[p] == MODE_BITS) begin
                    send_bits_traffic(k);
                end else begin
                    send_word(random_event());
                    k = 1;
                end
                sent += k;
            end
        end

        settle();
        if (sb.outstanding() > 0) sb.n_errors += sb.outstanding();

        $display("Covered %0d input words and %0d results over %0d mode writes",
                 sb.n_words, sb.n_results, n_cfg);
        $display("(pass, pulse, bit and spare modes; %0d mismatches)", sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
